// ----- hdl/clr_pkg.sv -----
package clr_pkg;

	// Limits of the orbital space
	localparam int MAX_ORBITALS  = 64;
	localparam int MAX_ELECTRONS = 64;

	// Field widths
	localparam int IDX_W   = 7;
	localparam int ADDR_W  = 61;
	localparam int CFG_I_W = 2;

	// Pascal table: rows 0..MAX_ORBITALS, columns 0..MAX_ORBITALS
	localparam int TBL_ROWS  = MAX_ORBITALS + 1;
	localparam int TBL_DEPTH = TBL_ROWS * TBL_ROWS;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);

	// Configuration register indexes
	localparam logic [CFG_I_W-1:0] REG_ELECTRON_COUNT = 2'd0;
	localparam logic [CFG_I_W-1:0] REG_ORBITAL_COUNT  = 2'd1;

	typedef enum logic [2:0] {
		ST_BUILD,
		ST_IDLE,
		ST_SUM,
		ST_DRAIN,
		ST_EMIT
	} clr_state_t;

	// Controller to datapath
	typedef struct packed {
		logic build_step;
		logic take;
		logic sum_issue;
		logic emit;
	} clr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic build_done;
		logic need_sum;
		logic in_last;
		logic j_last;
		logic last;
		logic out_free;
	} clr_status_t;

endpackage

// ----- hdl/clr_if.sv -----
interface clr_in_if import clr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] orbital_index;
	logic             last_element;

	modport source (output valid, output orbital_index, output last_element, input ready);
	modport sink   (input valid, input orbital_index, input last_element, output ready);
endinterface

interface clr_out_if import clr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;
	logic              bad_string;

	modport source (output valid, output address, output bad_string, input ready);
	modport sink   (input valid, input address, input bad_string, output ready);
endinterface

interface clr_cfg_if import clr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CFG_I_W-1:0] index;
	logic [IDX_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/clr_ctrl.sv -----
module clr_ctrl import clr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  clr_status_t st,
	output clr_cmd_t    cmd
);

	clr_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BUILD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_BUILD: begin
				cmd.build_step = !st.build_done;
				if (st.build_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid) begin
					priority if (st.need_sum) begin
						state_d = ST_SUM;
					end else if (st.in_last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SUM: begin
				cmd.sum_issue = 1'b1;
				if (st.j_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = st.last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit = st.out_free;
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/clr_datapath.sv -----
module clr_datapath import clr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// input beat payload
	input  logic [IDX_W-1:0]   in_index,
	input  logic               in_last,
	// register writes
	input  logic               cfg_we,
	input  logic [CFG_I_W-1:0] cfg_index,
	input  logic [IDX_W-1:0]   cfg_data,
	// result beat
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  out_address,
	output logic               out_bad,
	// control
	input  clr_cmd_t           cmd,
	output clr_status_t        st
);

	// Row-major table address n*65 + k
	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [IDX_W-1:0] n,
			input logic [IDX_W-1:0] k);
		logic [TBL_AW-1:0] a;
		a = (TBL_AW'(n) * TBL_AW'(TBL_ROWS)) + TBL_AW'(k);
		return a;
	endfunction

	// Configuration
	logic [IDX_W-1:0] elec_q, orbs_q;

	// String state
	logic [IDX_W-1:0]  prev_q, pos_q, j_q, idx_q, kk_q;
	logic [ADDR_W-1:0] sum_q;
	logic              err_q, last_q;

	// Table build sweep
	logic [IDX_W-1:0]  bn_q, bk_q;
	logic              phase_q, build_done_q;
	logic [ADDR_W-1:0] left_q;

	// Table memory
	logic [ADDR_W-1:0] tbl_mem [TBL_DEPTH];
	logic [ADDR_W-1:0] rd_q;
	logic [TBL_AW-1:0] raddr, waddr;
	logic [ADDR_W-1:0] build_val;
	logic              build_we, build_upper;

	// Term pipeline
	logic pend_q, zero_q;

	// Result register
	logic              out_valid_q, out_bad_q;
	logic [ADDR_W-1:0] out_address_q;

	logic             cfg_ok, err_now, new_err, final_err;
	logic [IDX_W:0]   in_ext, prev_ext;
	logic [IDX_W-1:0] kk_next, n_sum;

	// Checks on an incoming index
	always_comb begin
		cfg_ok = (elec_q >= IDX_W'(1)) && (elec_q <= IDX_W'(MAX_ELECTRONS)) &&
			(orbs_q >= IDX_W'(1)) && (orbs_q <= IDX_W'(MAX_ORBITALS)) &&
			(elec_q <= orbs_q);
		in_ext   = {1'b0, in_index};
		prev_ext = {1'b0, prev_q};
		err_now  = !cfg_ok || (in_index == '0) || (in_index > orbs_q) ||
			(in_index <= prev_q) || (pos_q >= elec_q);
		new_err   = err_q || err_now;
		kk_next   = elec_q - pos_q - IDX_W'(1);
		n_sum     = orbs_q - j_q;
		final_err = err_q || (pos_q != elec_q);
	end

	// Build value: C(n,k) = C(n-1,k-1) + C(n-1,k)
	always_comb begin
		build_upper = bk_q < bn_q;
		build_we    = cmd.build_step && phase_q;
		if (bk_q == '0) begin
			build_val = ADDR_W'(1);
		end else begin
			build_val = left_q + (build_upper ? rd_q : '0);
		end
		waddr = tbl_addr(bn_q, bk_q);
		if (cmd.build_step) begin
			raddr = tbl_addr(bn_q - IDX_W'(1), bk_q);
		end else begin
			raddr = tbl_addr(n_sum, kk_q);
		end
	end

	// Table memory, registered read
	always_ff @(posedge clk) begin
		if (build_we) begin
			tbl_mem[waddr] <= build_val;
		end
		rd_q <= tbl_mem[raddr];
	end

	// Build sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bn_q         <= '0;
			bk_q         <= '0;
			phase_q      <= 1'b0;
			build_done_q <= 1'b0;
			left_q       <= '0;
		end else if (cmd.build_step) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				left_q <= build_upper ? rd_q : '0;
				if (bk_q == bn_q) begin
					bk_q <= '0;
					if (bn_q == IDX_W'(MAX_ORBITALS)) begin
						build_done_q <= 1'b1;
					end else begin
						bn_q <= bn_q + IDX_W'(1);
					end
				end else begin
					bk_q <= bk_q + IDX_W'(1);
				end
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elec_q <= IDX_W'(1);
			orbs_q <= IDX_W'(MAX_ORBITALS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ELECTRON_COUNT: elec_q <= cfg_data;
				REG_ORBITAL_COUNT:  orbs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// String state and gap summation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			pos_q  <= '0;
			sum_q  <= ADDR_W'(1);
			err_q  <= 1'b0;
			last_q <= 1'b0;
			j_q    <= '0;
			idx_q  <= '0;
			kk_q   <= '0;
			pend_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			pend_q <= cmd.sum_issue;
			if (pend_q) begin
				sum_q <= sum_q + (zero_q ? '0 : rd_q);
			end
			if (cmd.take) begin
				err_q  <= new_err;
				prev_q <= in_index;
				pos_q  <= (pos_q == '1) ? pos_q : pos_q + IDX_W'(1);
				j_q    <= prev_q + IDX_W'(1);
				idx_q  <= in_index;
				last_q <= in_last;
				kk_q   <= kk_next;
			end
			if (cmd.sum_issue) begin
				j_q    <= j_q + IDX_W'(1);
				zero_q <= kk_q > n_sum;
			end
			if (cmd.emit) begin
				prev_q <= '0;
				pos_q  <= '0;
				sum_q  <= ADDR_W'(1);
				err_q  <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_address_q <= final_err ? '0 : sum_q;
			out_bad_q     <= final_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_address = out_address_q;
	assign out_bad     = out_bad_q;

	// Status
	always_comb begin
		st.build_done = build_done_q;
		st.need_sum   = !new_err && (in_ext > prev_ext + (IDX_W + 1)'(1));
		st.in_last    = in_last;
		st.j_last     = j_q == (idx_q - IDX_W'(1));
		st.last       = last_q;
		st.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ----- hdl/combination_lexical_rank.sv -----
// Lexical address of an occupation string: indices arrive one per beat, ascending and
// 1-based, the final one flagged by last_element; the block returns the 1-based address
// of the string among all electron_count-subsets of orbital_count orbitals, or
// bad_string with address 0 if the string is malformed. After reset the block builds
// its Pascal table in an on-chip memory, one entry at a time over the 2145 entries
// with k <= n, and accepts no index until that is done (register writes are taken
// throughout). An index that follows its predecessor directly is taken in the idle
// state; when g orbitals lie between them the block makes one table read and one add
// per skipped orbital through the single table read port, then a drain state. A final
// index also passes the emit state to load the result register; the next string may
// start while that result waits to be taken.
module combination_lexical_rank import clr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	clr_in_if.sink   in_ch,
	clr_out_if.source out_ch,
	clr_cfg_if.sink  cfg
);

	clr_cmd_t    cmd;
	clr_status_t st;
	logic        in_ready;

	assign in_ch.ready = in_ready;
	assign cfg.ready   = 1'b1;

	clr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	clr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_index    (in_ch.orbital_index),
		.in_last     (in_ch.last_element),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_address (out_ch.address),
		.out_bad     (out_ch.bad_string),
		.cmd         (cmd),
		.st          (st)
	);

endmodule
